FILE: rtl/nnfs_pkg.sv
// Shared types, constants and pixel conversion for the nearest-neighbor frame scaler.
package nnfs_pkg;

    localparam int DEFAULT_MAX_DIMENSION = 4096;
    localparam int DEFAULT_OFFSET_BITS   = 24;
    localparam int DEFAULT_QUEUE_DEPTH   = 2;

    localparam int CNT_BITS     = 13;
    localparam int OUT_OFF_BITS = 24;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH      = 3'd0,
        REG_SRC_HEIGHT     = 3'd1,
        REG_DST_WIDTH      = 3'd2,
        REG_DST_HEIGHT     = 3'd3,
        REG_SRC_BPP        = 3'd4,
        REG_DST_BPP        = 3'd5,
        REG_SRC_ROW_STRIDE = 3'd6,
        REG_DST_ROW_STRIDE = 3'd7
    } t_reg_index;

    typedef enum logic {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] pixel_bytes;
    } t_in_item;

    typedef struct packed {
        logic [23:0] read_offset;
        logic        read_valid;
        logic [23:0] write_offset;
        logic [31:0] write_data;
        logic [2:0]  write_bytes;
        logic        row_last;
        logic        frame_last;
    } t_out_item;

    typedef struct packed {
        logic [12:0]        src_width;
        logic [12:0]        src_height;
        logic [12:0]        dst_width;
        logic [12:0]        dst_height;
        logic [2:0]         src_bytes_per_pixel;
        logic [2:0]         dst_bytes_per_pixel;
        logic [15:0]        src_row_stride;
        logic signed [16:0] dst_row_stride;
    } t_cfg;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  nbytes;
    } t_conv;

    function automatic t_conv convert(input logic [2:0] sb, input logic [2:0] db,
                                      input logic [31:0] px);
        t_conv      res;
        logic [2:0] n;
        res = '0;
        if (sb == db) begin
            n = (sb > 3'd4) ? 3'd4 : sb;
            res.nbytes = n;
            case (n)
                3'd1:    res.data = {24'b0, px[7:0]};
                3'd2:    res.data = {16'b0, px[15:0]};
                3'd3:    res.data = {8'b0, px[23:0]};
                3'd4:    res.data = px;
                default: res.data = '0;
            endcase
        end else if (sb == 3'd2 && db == 3'd3) begin
            res.nbytes = 3'd3;
            res.data   = {8'b0, px[6:2], 3'b0, px[1:0], px[15:13], 3'b0, px[12:8], 3'b0};
        end else if (sb == 3'd4 && db == 3'd3) begin
            res.nbytes = 3'd3;
            res.data   = {8'b0, px[23:0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/nnfs_regs.sv
// APB configuration register file for the frame scaler.
module nnfs_regs
    import nnfs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    t_reg_index reg_idx;
    logic       wr_en;

    assign reg_idx = t_reg_index'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width           <= 13'd1;
            r_cfg.src_height          <= 13'd1;
            r_cfg.dst_width           <= 13'd1;
            r_cfg.dst_height          <= 13'd1;
            r_cfg.src_bytes_per_pixel <= 3'd4;
            r_cfg.dst_bytes_per_pixel <= 3'd4;
            r_cfg.src_row_stride      <= 16'd1;
            r_cfg.dst_row_stride      <= 17'sd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SRC_WIDTH:      r_cfg.src_width           <= pwdata[12:0];
                REG_SRC_HEIGHT:     r_cfg.src_height          <= pwdata[12:0];
                REG_DST_WIDTH:      r_cfg.dst_width           <= pwdata[12:0];
                REG_DST_HEIGHT:     r_cfg.dst_height          <= pwdata[12:0];
                REG_SRC_BPP:        r_cfg.src_bytes_per_pixel <= pwdata[2:0];
                REG_DST_BPP:        r_cfg.dst_bytes_per_pixel <= pwdata[2:0];
                REG_SRC_ROW_STRIDE: r_cfg.src_row_stride      <= pwdata[15:0];
                REG_DST_ROW_STRIDE: r_cfg.dst_row_stride      <= pwdata[16:0];
                default:            r_cfg                     <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_WIDTH:      prdata = {19'b0, r_cfg.src_width};
            REG_SRC_HEIGHT:     prdata = {19'b0, r_cfg.src_height};
            REG_DST_WIDTH:      prdata = {19'b0, r_cfg.dst_width};
            REG_DST_HEIGHT:     prdata = {19'b0, r_cfg.dst_height};
            REG_SRC_BPP:        prdata = {29'b0, r_cfg.src_bytes_per_pixel};
            REG_DST_BPP:        prdata = {29'b0, r_cfg.dst_bytes_per_pixel};
            REG_SRC_ROW_STRIDE: prdata = {16'b0, r_cfg.src_row_stride};
            REG_DST_ROW_STRIDE: prdata = {15'b0, r_cfg.dst_row_stride};
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: rtl/nnfs_queue.sv
// Small register queue that decouples producer and consumer transactions.
module nnfs_queue #(
    parameter int DATA_BITS = 33,
    parameter int DEPTH     = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output logic                 o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [PW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]        r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]        r_count, n_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/nnfs_div.sv
// Restoring divider that retires one quotient bit per cycle.
module nnfs_div #(
    parameter int DIM_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIM_BITS-1:0] i_dividend,
    input  logic [DIM_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [DIM_BITS-1:0] o_quotient,
    output logic [DIM_BITS-1:0] o_remainder
);

    localparam int CW = $clog2(DIM_BITS + 1);

    logic [DIM_BITS-1:0] r_quo, r_rem, r_div;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [DIM_BITS:0]   rem_shift, diff;
    logic                ge;

    assign rem_shift   = {r_rem, r_quo[DIM_BITS-1]};
    assign diff        = rem_shift - {1'b0, r_div};
    assign ge          = (rem_shift >= {1'b0, r_div});
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIM_BITS-1:0] : rem_shift[DIM_BITS-1:0];
            r_quo <= {r_quo[DIM_BITS-2:0], ge};
        end
    end

endmodule

FILE: rtl/nnfs_engine.sv
// Back end: frame walk, error accumulators, offset update and pixel conversion.
module nnfs_engine
    import nnfs_pkg::*;
#(
    parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION,
    parameter int OFFSET_BITS   = DEFAULT_OFFSET_BITS,
    parameter int DIM_BITS      = $clog2(DEFAULT_MAX_DIMENSION + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_empty,
    input  t_in_item  i_in_item,
    output logic      o_in_pop,
    input  logic      i_out_full,
    output logic      o_out_push,
    output t_out_item o_out_item
);

    localparam int STEP_BITS   = CNT_BITS + 1;
    localparam int COL_PBITS   = STEP_BITS + 3;
    localparam int ROW_PBITS   = STEP_BITS + 16;
    localparam int FLIP_PBITS  = 17 + DIM_BITS;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_DIV_COL = 3'b010,
        S_DIV_ROW = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [OFFSET_BITS-1:0] r_src_row_base, n_src_row_base;
    logic [OFFSET_BITS-1:0] r_src_pix, n_src_pix;
    logic [OFFSET_BITS-1:0] r_dst_row_base, n_dst_row_base;
    logic [OFFSET_BITS-1:0] r_dst_pix, n_dst_pix;
    logic [CNT_BITS-1:0]    r_col_cnt, n_col_cnt;
    logic [CNT_BITS-1:0]    r_row_cnt, n_row_cnt;
    logic [CNT_BITS-1:0]    r_col_err, n_col_err;
    logic [CNT_BITS-1:0]    r_row_err, n_row_err;
    logic [CNT_BITS-1:0]    r_col_quo, n_col_quo;
    logic [CNT_BITS-1:0]    r_col_rem, n_col_rem;
    logic [CNT_BITS-1:0]    r_row_quo, n_row_quo;
    logic [CNT_BITS-1:0]    r_row_rem, n_row_rem;

    logic [DIM_BITS-1:0]    sw, sh, dw, dh;
    logic signed [16:0]     ds;
    logic [16:0]            ds_mag;
    logic [CNT_BITS:0]      col_sum, row_sum;
    logic [CNT_BITS-1:0]    col_err_next, row_err_next;
    logic [STEP_BITS-1:0]   col_step, row_step;
    logic [COL_PBITS-1:0]   col_prod;
    logic [ROW_PBITS-1:0]   row_prod;
    logic [FLIP_PBITS-1:0]  flip_prod;
    logic [CNT_BITS-1:0]    col_next, row_next;
    t_conv                  conv;

    logic                   div_start, div_done;
    logic [DIM_BITS-1:0]    div_n, div_d, div_q, div_r;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CNT_BITS-1:0] v);
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (32'(v) > MAX_DIMENSION) begin
            res = DIM_BITS'(MAX_DIMENSION);
        end else begin
            res = DIM_BITS'(v);
        end
        return res;
    endfunction

    assign sw     = clamp_dim(i_cfg.src_width);
    assign sh     = clamp_dim(i_cfg.src_height);
    assign dw     = clamp_dim(i_cfg.dst_width);
    assign dh     = clamp_dim(i_cfg.dst_height);
    assign ds     = i_cfg.dst_row_stride;
    assign ds_mag = 17'd0 - ds;

    assign div_n  = (r_state == S_DIV_COL) ? sh : sw;
    assign div_d  = (r_state == S_DIV_COL) ? dh : dw;

    nnfs_div #(
        .DIM_BITS (DIM_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_n),
        .i_divisor   (div_d),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_comb begin
        col_sum = {1'b0, r_col_err} + {1'b0, r_col_rem};
        if (32'(col_sum) >= 32'(dw)) begin
            col_err_next = CNT_BITS'(32'(col_sum) - 32'(dw));
            col_step     = {1'b0, r_col_quo} + STEP_BITS'(1);
        end else begin
            col_err_next = col_sum[CNT_BITS-1:0];
            col_step     = {1'b0, r_col_quo};
        end
        row_sum = {1'b0, r_row_err} + {1'b0, r_row_rem};
        if (32'(row_sum) >= 32'(dh)) begin
            row_err_next = CNT_BITS'(32'(row_sum) - 32'(dh));
            row_step     = {1'b0, r_row_quo} + STEP_BITS'(1);
        end else begin
            row_err_next = row_sum[CNT_BITS-1:0];
            row_step     = {1'b0, r_row_quo};
        end
        col_prod  = COL_PBITS'(col_step) * COL_PBITS'(i_cfg.src_bytes_per_pixel);
        row_prod  = ROW_PBITS'(row_step) * ROW_PBITS'(i_cfg.src_row_stride);
        flip_prod = FLIP_PBITS'(ds_mag) * FLIP_PBITS'(dh - DIM_BITS'(1));
        col_next  = r_col_cnt + CNT_BITS'(1);
        row_next  = r_row_cnt + CNT_BITS'(1);
        conv      = convert(i_cfg.src_bytes_per_pixel, i_cfg.dst_bytes_per_pixel,
                            i_in_item.pixel_bytes);
    end

    always_comb begin
        n_state        = r_state;
        n_src_row_base = r_src_row_base;
        n_src_pix      = r_src_pix;
        n_dst_row_base = r_dst_row_base;
        n_dst_pix      = r_dst_pix;
        n_col_cnt      = r_col_cnt;
        n_row_cnt      = r_row_cnt;
        n_col_err      = r_col_err;
        n_row_err      = r_row_err;
        n_col_quo      = r_col_quo;
        n_col_rem      = r_col_rem;
        n_row_quo      = r_row_quo;
        n_row_rem      = r_row_rem;
        div_start      = 1'b0;
        o_in_pop       = 1'b0;
        o_out_push     = 1'b0;
        o_out_item     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_in_empty && !i_out_full) begin
                    o_in_pop = 1'b1;
                    if (i_in_item.op == OP_START) begin
                        div_start = 1'b1;
                        n_state   = S_DIV_COL;
                    end else begin
                        o_out_push = 1'b1;
                        if (32'(r_row_cnt) < 32'(dh)) begin
                            o_out_item.write_offset =
                                OUT_OFF_BITS'(32'(OFFSET_BITS'(r_dst_row_base + r_dst_pix)));
                            o_out_item.write_data  = conv.data;
                            o_out_item.write_bytes = conv.nbytes;
                            o_out_item.read_valid  = 1'b1;
                            n_col_err = col_err_next;
                            n_src_pix = r_src_pix + OFFSET_BITS'(32'(col_prod));
                            n_dst_pix = r_dst_pix
                                      + OFFSET_BITS'(i_cfg.dst_bytes_per_pixel);
                            n_col_cnt = col_next;
                            if (32'(col_next) >= 32'(dw)) begin
                                o_out_item.row_last = 1'b1;
                                n_col_cnt      = '0;
                                n_col_err      = '0;
                                n_src_pix      = '0;
                                n_dst_pix      = '0;
                                n_row_err      = row_err_next;
                                n_src_row_base = r_src_row_base
                                               + OFFSET_BITS'(32'(row_prod));
                                n_dst_row_base = r_dst_row_base + OFFSET_BITS'(ds);
                                n_row_cnt      = row_next;
                                if (32'(row_next) >= 32'(dh)) begin
                                    o_out_item.frame_last = 1'b1;
                                    o_out_item.read_valid = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            S_DIV_COL: begin
                if (div_done) begin
                    n_col_quo = CNT_BITS'(32'(div_q));
                    n_col_rem = CNT_BITS'(32'(div_r));
                    div_start = 1'b1;
                    n_state   = S_DIV_ROW;
                end
            end
            S_DIV_ROW: begin
                if (div_done) begin
                    n_row_quo      = CNT_BITS'(32'(div_q));
                    n_row_rem      = CNT_BITS'(32'(div_r));
                    n_src_row_base = '0;
                    n_src_pix      = '0;
                    n_dst_pix      = '0;
                    n_dst_row_base = ds[16] ? OFFSET_BITS'(32'(flip_prod)) : '0;
                    n_col_cnt      = '0;
                    n_row_cnt      = '0;
                    n_col_err      = '0;
                    n_row_err      = '0;
                    o_out_push     = 1'b1;
                    o_out_item.read_valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_out_item.read_offset =
            OUT_OFF_BITS'(32'(OFFSET_BITS'(n_src_row_base + n_src_pix)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_src_row_base <= '0;
            r_src_pix      <= '0;
            r_dst_row_base <= '0;
            r_dst_pix      <= '0;
            r_col_cnt      <= '0;
            r_row_cnt      <= '0;
            r_col_err      <= '0;
            r_row_err      <= '0;
            r_col_quo      <= '0;
            r_col_rem      <= '0;
            r_row_quo      <= '0;
            r_row_rem      <= '0;
        end else begin
            r_state        <= n_state;
            r_src_row_base <= n_src_row_base;
            r_src_pix      <= n_src_pix;
            r_dst_row_base <= n_dst_row_base;
            r_dst_pix      <= n_dst_pix;
            r_col_cnt      <= n_col_cnt;
            r_row_cnt      <= n_row_cnt;
            r_col_err      <= n_col_err;
            r_row_err      <= n_row_err;
            r_col_quo      <= n_col_quo;
            r_col_rem      <= n_col_rem;
            r_row_quo      <= n_row_quo;
            r_row_rem      <= n_row_rem;
        end
    end

endmodule

FILE: rtl/nearest_neighbour_frame_scaler_core.sv
// Nearest-neighbor frame scaler: top level with APB registers, input and result queues.
// Walks a destination frame and names the source pixel for each destination pixel,
// converting RGB555 or 32-bit pixels to 24-bit or copying equal sizes. Every item
// returns exactly one result. Pixels stream through the engine at one per cycle while
// the input queue holds items and the result queue is drained; with both queues empty,
// an accepted pixel item is registered in the input queue, then in the result queue,
// before empty goes low. A start item occupies the engine while the shared
// one-bit-per-cycle divider computes the column and row step ratios one after the
// other. Write registers only while the block is idle.
module nearest_neighbour_frame_scaler_core
    import nnfs_pkg::*;
#(
    parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION,
    parameter int OFFSET_BITS   = DEFAULT_OFFSET_BITS,
    parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  t_in_item                 i_in_item,
    input  logic                     pop,
    output logic                     empty,
    output t_out_item                o_out_item
);

    localparam int DIM_BITS = $clog2(MAX_DIMENSION + 1);
    localparam int IN_BITS  = $bits(t_in_item);
    localparam int OUT_BITS = $bits(t_out_item);

    t_cfg                cfg;
    logic [IN_BITS-1:0]  in_q_data;
    logic [OUT_BITS-1:0] out_q_data;
    t_out_item           eng_item;
    logic                in_empty, in_pop;
    logic                out_full, out_push;

    nnfs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    nnfs_queue #(
        .DATA_BITS (IN_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_in_item),
        .o_full  (full),
        .i_pop   (in_pop),
        .o_data  (in_q_data),
        .o_empty (in_empty)
    );

    nnfs_engine #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .OFFSET_BITS   (OFFSET_BITS),
        .DIM_BITS      (DIM_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_empty (in_empty),
        .i_in_item  (t_in_item'(in_q_data)),
        .o_in_pop   (in_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_item (eng_item)
    );

    nnfs_queue #(
        .DATA_BITS (OUT_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (eng_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_q_data),
        .o_empty (empty)
    );

    assign o_out_item = t_out_item'(out_q_data);

endmodule

FILE: test/tb.sv
// Self-checking testbench for the nearest-neighbor frame scaler core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nnfs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int RANDOM_ITEMS = 1850;

    class frame_walk_scoreboard;
        t_cfg        cfg;
        logic [23:0] src_row_base, src_pixel_off, dst_row_base, dst_pixel_off;
        logic [12:0] col_count, row_count, col_err, row_err;
        logic [12:0] col_quot, col_rem, row_quot, row_rem;
        t_out_item   expected_results[$];
        int          failures;

        function new();
            cfg = '0;
            cfg.src_width = 13'd1;
            cfg.src_height = 13'd1;
            cfg.dst_width = 13'd1;
            cfg.dst_height = 13'd1;
            cfg.src_bytes_per_pixel = 3'd4;
            cfg.dst_bytes_per_pixel = 3'd4;
            cfg.src_row_stride = 16'd1;
            cfg.dst_row_stride = 17'sd1;
            src_row_base = '0;
            src_pixel_off = '0;
            dst_row_base = '0;
            dst_pixel_off = '0;
            col_count = '0;
            row_count = '0;
            col_err = '0;
            row_err = '0;
            col_quot = '0;
            col_rem = '0;
            row_quot = '0;
            row_rem = '0;
            failures = 0;
        endfunction

        function void write_reg(t_reg_index idx, logic [31:0] value);
            case (idx)
                REG_SRC_WIDTH:      cfg.src_width = value[12:0];
                REG_SRC_HEIGHT:     cfg.src_height = value[12:0];
                REG_DST_WIDTH:      cfg.dst_width = value[12:0];
                REG_DST_HEIGHT:     cfg.dst_height = value[12:0];
                REG_SRC_BPP:        cfg.src_bytes_per_pixel = value[2:0];
                REG_DST_BPP:        cfg.dst_bytes_per_pixel = value[2:0];
                REG_SRC_ROW_STRIDE: cfg.src_row_stride = value[15:0];
                REG_DST_ROW_STRIDE: cfg.dst_row_stride = value[16:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp_size(logic [12:0] v);
            if (v == 13'd0) return 1;
            if (v > DEFAULT_MAX_DIMENSION) return DEFAULT_MAX_DIMENSION;
            return v;
        endfunction

        function void convert_pixel(input logic [31:0] px, output logic [31:0] data,
                                    output logic [2:0] nbytes);
            logic [7:0]  b0, b1, d0, d1, d2;
            int unsigned sb, db, cnt;
            sb = cfg.src_bytes_per_pixel;
            db = cfg.dst_bytes_per_pixel;
            b0 = px[7:0];
            b1 = px[15:8];
            data = '0;
            nbytes = '0;
            if (sb == db) begin
                cnt = (sb > 4) ? 4 : sb;
                nbytes = 3'(cnt);
                data = 32'(px & ((64'd1 << (8 * cnt)) - 64'd1));
            end else if (sb == 2 && db == 3) begin
                d0 = {b1[4:0], 3'b000};
                d1 = {b0[1:0], b1[7:5], 3'b000};
                d2 = {b0[6:2], 3'b000};
                nbytes = 3'd3;
                data = {8'h00, d2, d1, d0};
            end else if (sb == 4 && db == 3) begin
                nbytes = 3'd3;
                data = {8'h00, px[23:0]};
            end
        endfunction

        function void take_item(t_in_item item);
            int unsigned sw, sh, dw, dh, sum, advance;
            longint      stride;
            t_out_item   r;
            sw = clamp_size(cfg.src_width);
            sh = clamp_size(cfg.src_height);
            dw = clamp_size(cfg.dst_width);
            dh = clamp_size(cfg.dst_height);
            stride = longint'($signed(cfg.dst_row_stride));
            r = '0;
            if (item.op == OP_START) begin
                col_quot = 13'(sw / dw);
                col_rem = 13'(sw % dw);
                row_quot = 13'(sh / dh);
                row_rem = 13'(sh % dh);
                src_row_base = '0;
                src_pixel_off = '0;
                dst_pixel_off = '0;
                dst_row_base = (stride < 0) ? 24'((-stride) * longint'(dh - 1)) : '0;
                col_count = '0;
                row_count = '0;
                col_err = '0;
                row_err = '0;
                r.read_valid = 1'b1;
            end else if (row_count < dh) begin
                r.write_offset = dst_row_base + dst_pixel_off;
                convert_pixel(item.pixel_bytes, r.write_data, r.write_bytes);
                sum = col_err + col_rem;
                advance = col_quot;
                if (sum >= dw) begin
                    sum -= dw;
                    advance++;
                end
                col_err = 13'(sum);
                src_pixel_off = 24'(longint'(src_pixel_off)
                                    + longint'(advance) * cfg.src_bytes_per_pixel);
                dst_pixel_off = dst_pixel_off + 24'(cfg.dst_bytes_per_pixel);
                col_count = col_count + 13'd1;
                r.read_valid = 1'b1;
                if (col_count >= dw) begin
                    r.row_last = 1'b1;
                    col_count = '0;
                    col_err = '0;
                    src_pixel_off = '0;
                    dst_pixel_off = '0;
                    sum = row_err + row_rem;
                    advance = row_quot;
                    if (sum >= dh) begin
                        sum -= dh;
                        advance++;
                    end
                    row_err = 13'(sum);
                    src_row_base = 24'(longint'(src_row_base)
                                       + longint'(advance) * cfg.src_row_stride);
                    dst_row_base = 24'(longint'(dst_row_base) + stride);
                    row_count = row_count + 13'd1;
                    if (row_count >= dh) begin
                        r.frame_last = 1'b1;
                        r.read_valid = 1'b0;
                    end
                end
            end
            r.read_offset = src_row_base + src_pixel_off;
            expected_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with no transaction outstanding: ro=%h wo=%h wd=%h",
                             $time, got.read_offset, got.write_offset, got.write_data);
                return;
            end
            want = expected_results.pop_front();
            if (got.read_offset !== want.read_offset || got.read_valid !== want.read_valid
                || got.write_offset !== want.write_offset
                || got.write_data !== want.write_data
                || got.write_bytes !== want.write_bytes || got.row_last !== want.row_last
                || got.frame_last !== want.frame_last) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch want ro=%h rv=%b wo=%h wd=%h wb=%0d rl=%b fl=%b",
                             $time, want.read_offset, want.read_valid, want.write_offset,
                             want.write_data, want.write_bytes, want.row_last,
                             want.frame_last, " got ro=%h rv=%b wo=%h wd=%h wb=%0d rl=%b fl=%b",
                             got.read_offset, got.read_valid, got.write_offset,
                             got.write_data, got.write_bytes, got.row_last, got.frame_last);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     push = 1'b0;
    logic                     full;
    t_in_item                 i_in_item = '0;
    logic                     pop = 1'b0;
    logic                     empty;
    t_out_item                o_out_item;

    frame_walk_scoreboard sb;
    bit hold_req = 1'b0;
    int burst_left = 0;
    int stall_cycles = 0;

    nearest_neighbour_frame_scaler_core dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic t_in_item start_item();
        t_in_item it;
        it.op = OP_START;
        it.pixel_bytes = $urandom;
        return it;
    endfunction

    function automatic t_in_item pixel_item(logic [31:0] data);
        t_in_item it;
        it.op = OP_PIXEL;
        it.pixel_bytes = data;
        return it;
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [12:0] random_dim();
        case ($urandom_range(0, 19))
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'h1FFF;
            3:       return 13'($urandom_range(4097, 8191));
            4, 5:    return 13'($urandom_range(13, 4095));
            default: return 13'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic t_cfg make_cfg(logic [12:0] sw, logic [12:0] sh, logic [12:0] dw,
                                      logic [12:0] dh, logic [2:0] sbpp, logic [2:0] dbpp,
                                      logic [15:0] sstride, logic [16:0] dstride);
        t_cfg c;
        c.src_width = sw;
        c.src_height = sh;
        c.dst_width = dw;
        c.dst_height = dh;
        c.src_bytes_per_pixel = sbpp;
        c.dst_bytes_per_pixel = dbpp;
        c.src_row_stride = sstride;
        c.dst_row_stride = dstride;
        return c;
    endfunction

    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg c);
        write_reg(REG_SRC_WIDTH, {19'b0, c.src_width});
        write_reg(REG_SRC_HEIGHT, {19'b0, c.src_height});
        write_reg(REG_DST_WIDTH, {19'b0, c.dst_width});
        write_reg(REG_DST_HEIGHT, {19'b0, c.dst_height});
        write_reg(REG_SRC_BPP, {29'b0, c.src_bytes_per_pixel});
        write_reg(REG_DST_BPP, {29'b0, c.dst_bytes_per_pixel});
        write_reg(REG_SRC_ROW_STRIDE, {16'b0, c.src_row_stride});
        write_reg(REG_DST_ROW_STRIDE, {15'b0, c.dst_row_stride});
    endtask

    task automatic send_items(input t_in_item items[$], input bit no_gaps);
        foreach (items[k]) begin
            if (!no_gaps && burst_left <= 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                          : $urandom_range(1, 16);
            end
            burst_left--;
            i_in_item <= items[k];
            push <= 1'b1;
            do @(posedge i_clk); while (full);
            sb.take_item(items[k]);
        end
        push <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_out_item);
        if (!i_rst_n || (push && !full) || (pop && !empty) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("nearest_neighbour_frame_scaler_core regression: fail");
            $finish;
        end
    end

    initial begin
        int span;
        int mode;
        int tick;
        span = 0;
        mode = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                hold_req = 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(8, 80);
                end
                span--;
                tick++;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= (tick % 4 == 0);
                    default: pop <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        t_cfg     c;
        t_in_item stim[$];
        int       frame_px;
        int       n_px;
        int       target;
        int       random_items;
        int       phase;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pixels before any start, a one-pixel frame, a pixel past the frame end
        stim = '{pixel_item(32'h0000_0000), pixel_item(32'hFFFF_FFFF), start_item(),
                 pixel_item(32'hA5C3_5A3C), pixel_item(32'h1234_5678)};
        send_items(stim, 1'b0);
        wait_idle();

        // RGB555 upscale, zero source height, bottom-up destination
        write_cfg(make_cfg(13'd3, 13'd0, 13'd5, 13'd2, 3'd2, 3'd3, 16'hFFFF, 17'h10001));
        stim = '{start_item(), pixel_item(32'h0000_FFFF), pixel_item(32'h0000_0000),
                 pixel_item(32'h0000_007C), pixel_item(32'h0000_0003),
                 pixel_item(32'h0000_E000), pixel_item(32'h0000_1F00),
                 pixel_item(32'hFFFF_0000), pixel_item(32'h0000_8001),
                 pixel_item(32'h5555_AAAA), pixel_item(32'hAAAA_5555),
                 pixel_item(32'h0000_FFFF)};
        send_items(stim, 1'b0);
        wait_idle();

        // 32-bit to 24-bit, oversized and zero dimensions, most negative stride
        write_cfg(make_cfg(13'h1FFF, 13'd4096, 13'd4096, 13'd0, 3'd4, 3'd3, 16'h0000,
                           17'h10000));
        stim = '{start_item(), pixel_item(32'hFFFF_FFFF), pixel_item(32'h8000_0001),
                 pixel_item(32'h00FF_FF00)};
        send_items(stim, 1'b0);
        wait_idle();

        // unsupported format pair
        write_cfg(make_cfg(13'd1, 13'd1, 13'd1, 13'd1, 3'd1, 3'd4, 16'd1, 17'h0FFFF));
        stim = '{start_item(), pixel_item(32'hDEAD_BEEF), pixel_item(32'h0123_4567)};
        send_items(stim, 1'b0);
        wait_idle();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            c.src_width = random_dim();
            c.src_height = random_dim();
            c.dst_width = random_dim();
            c.dst_height = random_dim();
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    c.src_bytes_per_pixel = 3'($urandom_range(1, 4));
                    c.dst_bytes_per_pixel = c.src_bytes_per_pixel;
                end
                4, 5: begin
                    c.src_bytes_per_pixel = 3'd2;
                    c.dst_bytes_per_pixel = 3'd3;
                end
                6: begin
                    c.src_bytes_per_pixel = 3'd4;
                    c.dst_bytes_per_pixel = 3'd3;
                end
                7: begin
                    c.src_bytes_per_pixel = 3'($urandom_range(0, 7));
                    c.dst_bytes_per_pixel = 3'($urandom_range(0, 7));
                end
                default: begin
                    c.src_bytes_per_pixel = 3'($urandom_range(0, 7));
                    c.dst_bytes_per_pixel = c.src_bytes_per_pixel;
                end
            endcase
            case ($urandom_range(0, 7))
                0:       c.src_row_stride = 16'h0000;
                1:       c.src_row_stride = 16'hFFFF;
                2:       c.src_row_stride = 16'($urandom);
                default: c.src_row_stride = 16'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 9))
                0:       c.dst_row_stride = 17'h10000;
                1:       c.dst_row_stride = 17'h10001;
                2:       c.dst_row_stride = 17'h0FFFF;
                3:       c.dst_row_stride = 17'h00000;
                4:       c.dst_row_stride = 17'($urandom);
                5, 6:    c.dst_row_stride = -17'($urandom_range(1, 4096));
                default: c.dst_row_stride = 17'($urandom_range(1, 4096));
            endcase
            write_cfg(c);

            target = (phase == 2) ? 150 : $urandom_range(30, 160);
            stim = {};
            if ($urandom_range(0, 4) == 0) begin
                while (stim.size() < target)
                    stim.push_back(($urandom_range(0, 9) == 0) ? start_item()
                                                                : pixel_item(random_pixel()));
            end else begin
                // continue the previous walk under the new settings
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 8)) stim.push_back(pixel_item(random_pixel()));
                frame_px = sb.clamp_size(c.dst_width) * sb.clamp_size(c.dst_height);
                while (stim.size() < target) begin
                    stim.push_back(start_item());
                    if (frame_px > 200)
                        n_px = $urandom_range(1, 150);
                    else if ($urandom_range(0, 5) == 0)
                        n_px = $urandom_range(0, frame_px);
                    else
                        n_px = frame_px + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                                       : 0);
                    repeat (n_px) stim.push_back(pixel_item(random_pixel()));
                end
            end
            if (phase == 2)
                hold_req = 1'b1;
            send_items(stim, phase == 2);
            wait_idle();
            random_items += stim.size();
            phase++;
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("nearest_neighbour_frame_scaler_core regression: pass");
        else
            $display("nearest_neighbour_frame_scaler_core regression: fail");
        $finish;
    end
endmodule

FILE: nearest_neighbour_frame_scaler_core.f
rtl/nnfs_pkg.sv
rtl/nnfs_regs.sv
rtl/nnfs_queue.sv
rtl/nnfs_div.sv
rtl/nnfs_engine.sv
rtl/nearest_neighbour_frame_scaler_core.sv
test/tb.sv
